// ----- src/apsa_pkg.sv -----
// Shared types and constants for the averaged power spectrum accumulator.
`default_nettype none

package apsa_pkg;

    // Field widths
    localparam int BIN_W       = 10;
    localparam int SAMPLE_W    = 24;
    localparam int MAG_W       = 24;
    localparam int SQ_W        = 47;
    localparam int POWER_W     = 48;
    localparam int SUM_W       = 58;
    localparam int LO_W        = 32;
    localparam int HI_W        = SUM_W - LO_W;
    localparam int PROD_W      = 2 * LO_W;
    localparam int SCALE_W     = 32;
    localparam int FREQ_W      = 32;
    localparam int AMP_W       = 32;
    localparam int BINS_W      = 11;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;

    // Scaled sum and square root widths
    localparam int SCALED_W = SUM_W + 1;
    localparam int ROOT_W   = (SCALED_W + 1) / 2;
    localparam int REM_W    = 2 * ROOT_W;

    // Command queue between front and back
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    // Register reset values
    localparam logic [BINS_W-1:0] BINS_RESET = BINS_W'(1024);

    typedef enum logic [0:0] {
        OP_ACCUM = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BINS_IN_USE  = 2'd0,
        REG_FIRST_FREQ   = 2'd1,
        REG_AMP_SCALE    = 2'd2
    } reg_index_t;

    typedef struct packed {
        op_t                        opcode;
        logic [BIN_W-1:0]           bin;
        logic signed [SAMPLE_W-1:0] sample_re;
        logic signed [SAMPLE_W-1:0] sample_im;
    } in_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_index;
        logic [AMP_W-1:0]  amplitude;
        logic              bin_error;
    } out_t;

    typedef struct packed {
        op_t                opcode;
        logic [BIN_W-1:0]   bin;
        logic               ok;
        logic [FREQ_W-1:0]  freq_index;
        logic [POWER_W-1:0] power;
    } cmd_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_index;
        logic              err;
    } tag_t;

endpackage

`default_nettype wire

// ----- src/averaged_power_spectrum_accumulator.sv -----
// Top level of the averaged power spectrum accumulator: config, queue, output register.
// Throughput: one beat per cycle on each side, accumulate and read beats mixed freely,
// while full is low and results are popped; a read result passes through
// the front stages, the queue slot, four memory and scaling stages,
// a 30-stage square root and the output register.
// An accumulate writes its bin from the first back stage; later beats see it at once.
// Reset clears control state and starts a zeroing sweep of the whole sum memory;
// full stays high during the sweep, while configuration writes are taken as usual.
`default_nettype none

module averaged_power_spectrum_accumulator #(
    parameter int NUM_BINS = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire apsa_pkg::in_t                     item,
    output logic                                   empty,
    input  wire logic                              pop,
    output apsa_pkg::out_t                         result,
    input  wire logic                              cfg_write,
    input  wire logic [apsa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [apsa_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import apsa_pkg::*;

    logic [BINS_W-1:0]     bins_in_use_reg;
    logic [FREQ_W-1:0]     first_freq_reg;
    logic [SCALE_W-1:0]    scale_reg;

    logic                  accept;
    logic                  adv;
    logic                  q_push;
    cmd_t                  q_wdata;
    logic                  q_pop;
    cmd_t                  q_head;
    logic                  q_empty;
    logic                  q_full;
    logic [CMD_CNT_W-1:0]  q_count;
    logic [1:0]            inflight;
    logic [CMD_CNT_W:0]    credit_used;
    logic                  clearing;

    logic                  sc_valid;
    tag_t                  sc_tag;
    logic [SCALED_W-1:0]   sc_x;
    logic                  sq_valid;
    logic [ROOT_W-1:0]     sq_root;
    tag_t                  sq_tag;

    logic                  out_valid_reg;
    out_t                  out_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bins_in_use_reg <= BINS_RESET;
            first_freq_reg  <= '0;
            scale_reg       <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_BINS_IN_USE: bins_in_use_reg <= cfg_data[BINS_W-1:0];
                REG_FIRST_FREQ:  first_freq_reg  <= cfg_data[FREQ_W-1:0];
                REG_AMP_SCALE:   scale_reg       <= cfg_data[SCALE_W-1:0];
                default:         ;
            endcase
        end
    end

    // Hold off input beats while the queue plus in-flight front beats could overflow
    assign credit_used = (CMD_CNT_W + 1)'(q_count) + (CMD_CNT_W + 1)'(inflight);
    assign full   = clearing || (credit_used >= (CMD_CNT_W + 1)'(CMD_DEPTH));
    assign accept = push && !full;

    // The back end moves whenever the output register can take a beat
    assign adv = !out_valid_reg || pop;

    apsa_front #(
        .NUM_BINS (NUM_BINS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .item             (item),
        .bins_in_use      (bins_in_use_reg),
        .first_freq_index (first_freq_reg),
        .push             (q_push),
        .cmd              (q_wdata),
        .inflight         (inflight)
    );

    apsa_fifo u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_push),
        .wdata (q_wdata),
        .rd    (q_pop),
        .rdata (q_head),
        .empty (q_empty),
        .full  (q_full),
        .count (q_count)
    );

    apsa_back #(
        .NUM_BINS (NUM_BINS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .scale     (scale_reg),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .out_valid (sc_valid),
        .out_tag   (sc_tag),
        .out_x     (sc_x)
    );

    apsa_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sc_valid),
        .in_x      (sc_x),
        .in_tag    (sc_tag),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_tag   (sq_tag)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.freq_index <= sq_tag.freq_index;
            out_reg.amplitude  <= sq_tag.err ? '0 : AMP_W'(sq_root);
            out_reg.bin_error  <= sq_tag.err;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    // The front never pushes into a full queue
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("command queue overflow");

    // Queue occupancy plus front beats stays within the queue depth
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_used <= (CMD_CNT_W + 1)'(CMD_DEPTH))
        else $error("credit bound exceeded");

    // No beat can have entered while the memory was being cleared
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clearing) |-> (q_count == '0) && (inflight == 2'd0))
        else $error("beat accepted during clearing sweep");

endmodule

`default_nettype wire

// ----- src/apsa_front.sv -----
// Front end: takes input beats, checks the bin, squares the sample into a command.
`default_nettype none

module apsa_front #(
    parameter int NUM_BINS = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire apsa_pkg::in_t                 item,
    input  wire logic [apsa_pkg::BINS_W-1:0]   bins_in_use,
    input  wire logic [apsa_pkg::FREQ_W-1:0]   first_freq_index,
    output logic                               push,
    output apsa_pkg::cmd_t                     cmd,
    output logic [1:0]                         inflight
);
    import apsa_pkg::*;

    logic                  ok_next;
    logic [FREQ_W-1:0]     freq_next;
    logic [SAMPLE_W-1:0]   raw_re;
    logic [SAMPLE_W-1:0]   raw_im;
    logic [MAG_W-1:0]      mag_re_next;
    logic [MAG_W-1:0]      mag_im_next;
    logic [2*MAG_W-1:0]    prod_re;
    logic [2*MAG_W-1:0]    prod_im;

    logic                  f1_valid_reg;
    op_t                   f1_op_reg;
    logic [BIN_W-1:0]      f1_bin_reg;
    logic                  f1_ok_reg;
    logic [FREQ_W-1:0]     f1_freq_reg;
    logic [MAG_W-1:0]      f1_mag_re_reg;
    logic [MAG_W-1:0]      f1_mag_im_reg;

    logic                  f2_valid_reg;
    op_t                   f2_op_reg;
    logic [BIN_W-1:0]      f2_bin_reg;
    logic                  f2_ok_reg;
    logic [FREQ_W-1:0]     f2_freq_reg;
    logic [SQ_W-1:0]       f2_sq_re_reg;
    logic [SQ_W-1:0]       f2_sq_im_reg;

    // Classify the bin and form the absolute frequency index
    assign ok_next = (BINS_W'(item.bin) < bins_in_use) && (32'(item.bin) < 32'(NUM_BINS));
    assign freq_next = first_freq_index + FREQ_W'(item.bin);

    // Take magnitudes; the most negative value maps to 2^23
    assign raw_re = item.sample_re;
    assign raw_im = item.sample_im;
    assign mag_re_next = raw_re[SAMPLE_W-1] ? MAG_W'(~raw_re + 24'd1) : raw_re;
    assign mag_im_next = raw_im[SAMPLE_W-1] ? MAG_W'(~raw_im + 24'd1) : raw_im;

    // Square each part
    assign prod_re = (2*MAG_W)'(f1_mag_re_reg) * (2*MAG_W)'(f1_mag_re_reg);
    assign prod_im = (2*MAG_W)'(f1_mag_im_reg) * (2*MAG_W)'(f1_mag_im_reg);

    // Advance stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= accept;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    // Capture stage payloads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_op_reg     <= item.opcode;
            f1_bin_reg    <= item.bin;
            f1_ok_reg     <= ok_next;
            f1_freq_reg   <= freq_next;
            f1_mag_re_reg <= mag_re_next;
            f1_mag_im_reg <= mag_im_next;
        end
        if (f1_valid_reg)
        begin
            f2_op_reg    <= f1_op_reg;
            f2_bin_reg   <= f1_bin_reg;
            f2_ok_reg    <= f1_ok_reg;
            f2_freq_reg  <= f1_freq_reg;
            f2_sq_re_reg <= SQ_W'(prod_re);
            f2_sq_im_reg <= SQ_W'(prod_im);
        end
    end

    // Hand the command to the queue
    assign push = f2_valid_reg;
    always_comb
    begin
        cmd.opcode     = f2_op_reg;
        cmd.bin        = f2_bin_reg;
        cmd.ok         = f2_ok_reg;
        cmd.freq_index = f2_freq_reg;
        cmd.power      = POWER_W'(f2_sq_re_reg) + POWER_W'(f2_sq_im_reg);
    end

    assign inflight = {1'b0, f1_valid_reg} + {1'b0, f2_valid_reg};

endmodule

`default_nettype wire

// ----- src/apsa_fifo.sv -----
// Short show-ahead command queue between the front and back ends.
`default_nettype none

module apsa_fifo (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            wr,
    input  wire apsa_pkg::cmd_t                  wdata,
    input  wire logic                            rd,
    output apsa_pkg::cmd_t                       rdata,
    output logic                                 empty,
    output logic                                 full,
    output logic [apsa_pkg::CMD_CNT_W-1:0]       count
);
    import apsa_pkg::*;

    cmd_t                   slot_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0]   wr_ptr_reg;
    logic [CMD_PTR_W-1:0]   rd_ptr_reg;
    logic [CMD_CNT_W-1:0]   count_reg;
    logic [CMD_PTR_W-1:0]   wr_ptr_next;
    logic [CMD_PTR_W-1:0]   rd_ptr_next;

    assign wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= wr_ptr_next;
            if (rd)
                rd_ptr_reg <= rd_ptr_next;
            if (wr && !rd)
                count_reg <= count_reg + 1'b1;
            else if (rd && !wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Store the incoming command
    always_ff @(posedge clk)
    begin
        if (wr)
            slot_reg[wr_ptr_reg] <= wdata;
    end

    assign rdata = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign count = count_reg;

endmodule

`default_nettype wire

// ----- src/apsa_back.sv -----
// Back end: power sum memory with read-modify-write, clearing pass and scaling.
`default_nettype none

module apsa_back #(
    parameter int NUM_BINS = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            adv,
    input  wire logic                            q_empty,
    input  wire apsa_pkg::cmd_t                  q_head,
    input  wire logic [apsa_pkg::SCALE_W-1:0]    scale,
    output logic                                 q_pop,
    output logic                                 clearing,
    output logic                                 out_valid,
    output apsa_pkg::tag_t                       out_tag,
    output logic [apsa_pkg::SCALED_W-1:0]        out_x
);
    import apsa_pkg::*;

    localparam int ADDR_W = $clog2(NUM_BINS);
    localparam int EXT_W  = BIN_W + ADDR_W;

    logic [SUM_W-1:0]    mem [NUM_BINS];

    logic                clear_reg;
    logic [ADDR_W-1:0]   clr_addr_reg;

    logic [EXT_W-1:0]    head_ext;
    logic [ADDR_W-1:0]   head_addr;

    logic                b1_valid_reg;
    cmd_t                b1_cmd_reg;
    logic [ADDR_W-1:0]   b1_addr_reg;
    logic [SUM_W-1:0]    rd_data_reg;
    logic                fwd_hit_reg;
    logic [SUM_W-1:0]    fwd_data_reg;

    logic [SUM_W-1:0]    operand;
    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    sum_sat;
    logic                b1_write;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_wa;
    logic [SUM_W-1:0]    mem_wd;
    logic [PROD_W-1:0]   lo_full;

    logic                b2_valid_reg;
    tag_t                b2_tag_reg;
    logic [HI_W-1:0]     b2_hi_reg;
    logic [LO_W-1:0]     b2_lo_prod_reg;

    logic                b3_valid_reg;
    tag_t                b3_tag_reg;
    logic [SUM_W-1:0]    b3_hi_prod_reg;
    logic [LO_W-1:0]     b3_lo_reg;

    logic                b4_valid_reg;
    tag_t                b4_tag_reg;
    logic [SCALED_W-1:0] b4_x_reg;

    // Map the bin onto a memory address
    assign head_ext  = EXT_W'(q_head.bin);
    assign head_addr = head_ext[ADDR_W-1:0];

    assign q_pop    = adv && !q_empty && !clear_reg;
    assign clearing = clear_reg;

    // Pick the freshest sum and add the new power with saturation
    assign operand  = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign sum_wide = {1'b0, operand} + (SUM_W + 1)'(b1_cmd_reg.power);
    assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    assign b1_write = b1_valid_reg && (b1_cmd_reg.opcode == OP_ACCUM) && b1_cmd_reg.ok;

    // Share the write port between clearing and accumulation
    assign mem_we = clear_reg || (adv && b1_write);
    assign mem_wa = clear_reg ? clr_addr_reg : b1_addr_reg;
    assign mem_wd = clear_reg ? '0 : sum_sat;

    assign lo_full = PROD_W'(operand[LO_W-1:0]) * PROD_W'(scale);

    // Sweep the memory to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clear_reg)
        begin
            if (clr_addr_reg == ADDR_W'(NUM_BINS - 1))
                clear_reg <= 1'b0;
            else
                clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Power sum memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (q_pop)
            rd_data_reg <= mem[head_addr];
    end

    // Advance stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_valid_reg <= q_pop;
            b2_valid_reg <= b1_valid_reg && (b1_cmd_reg.opcode == OP_READ);
            b3_valid_reg <= b2_valid_reg;
            b4_valid_reg <= b3_valid_reg;
        end
    end

    // Capture the popped command and bypass a same-bin write landing this edge
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b1_cmd_reg   <= q_head;
            b1_addr_reg  <= head_addr;
            fwd_hit_reg  <= b1_write && (b1_addr_reg == head_addr);
            fwd_data_reg <= sum_sat;
        end
    end

    // Scale the sum in two partial products, then add
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b2_tag_reg.freq_index <= b1_cmd_reg.freq_index;
            b2_tag_reg.err        <= !b1_cmd_reg.ok;
            b2_hi_reg             <= operand[SUM_W-1:LO_W];
            b2_lo_prod_reg        <= lo_full[PROD_W-1:LO_W];

            b3_tag_reg            <= b2_tag_reg;
            b3_hi_prod_reg        <= SUM_W'(b2_hi_reg) * SUM_W'(scale);
            b3_lo_reg             <= b2_lo_prod_reg;

            b4_tag_reg            <= b3_tag_reg;
            b4_x_reg              <= SCALED_W'(b3_hi_prod_reg) + SCALED_W'(b3_lo_reg);
        end
    end

    assign out_valid = b4_valid_reg;
    assign out_tag   = b4_tag_reg;
    assign out_x     = b4_x_reg;

endmodule

`default_nettype wire

// ----- src/apsa_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module apsa_isqrt (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            adv,
    input  wire logic                            in_valid,
    input  wire logic [apsa_pkg::SCALED_W-1:0]   in_x,
    input  wire apsa_pkg::tag_t                  in_tag,
    output logic                                 out_valid,
    output logic [apsa_pkg::ROOT_W-1:0]          out_root,
    output apsa_pkg::tag_t                       out_tag
);
    import apsa_pkg::*;

    logic [REM_W-1:0]   rem_pipe   [ROOT_W];
    logic [ROOT_W-1:0]  root_pipe  [ROOT_W+1];
    logic               valid_pipe [ROOT_W+1];
    tag_t               tag_pipe   [ROOT_W+1];

    assign rem_pipe[0]   = REM_W'(in_x);
    assign root_pipe[0]  = '0;
    assign valid_pipe[0] = in_valid;
    assign tag_pipe[0]   = in_tag;

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        localparam int BIT = ROOT_W - 1 - k;

        logic [REM_W-1:0]  trial;
        logic              take;
        logic              valid_reg;
        logic [ROOT_W-1:0] root_reg;
        tag_t              tag_reg;

        // Try setting this root bit against the remainder
        assign trial = (REM_W'(root_pipe[k]) << (BIT + 1)) | (REM_W'(1) << (2 * BIT));
        assign take  = (rem_pipe[k] >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg <= 1'b0;
            else if (adv)
                valid_reg <= valid_pipe[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                root_reg <= take ? (root_pipe[k] | (ROOT_W'(1) << BIT)) : root_pipe[k];
                tag_reg  <= tag_pipe[k];
            end
        end

        // Keep the remainder only where a later stage needs it
        if (k < ROOT_W - 1)
        begin : g_rem
            logic [REM_W-1:0] rem_reg;

            always_ff @(posedge clk)
            begin
                if (adv)
                    rem_reg <= take ? (rem_pipe[k] - trial) : rem_pipe[k];
            end

            assign rem_pipe[k+1] = rem_reg;
        end

        assign root_pipe[k+1]  = root_reg;
        assign valid_pipe[k+1] = valid_reg;
        assign tag_pipe[k+1]   = tag_reg;
    end

    assign out_valid = valid_pipe[ROOT_W];
    assign out_root  = root_pipe[ROOT_W];
    assign out_tag   = tag_pipe[ROOT_W];

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Testbench for the averaged power spectrum accumulator: driver, monitor and bin power predictor.
`timescale 1ns / 100ps

module tb;
    import apsa_pkg::*;

    localparam int NUM_BINS       = 1024;
    localparam int LATENCY_PAD    = 45;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_BEATS    = 160;
    localparam int SAT_BEATS      = 800;
    localparam int HOT_BIN        = 7;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [63:0] SUM_LIMIT = (64'd1 << SUM_W) - 64'd1;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    in_t                    item = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    out_t                   result;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Predictor state: register copies and one power sum per bin
    logic [BINS_W-1:0]  spec_bins = BINS_RESET;
    logic [FREQ_W-1:0]  spec_first_freq = '0;
    logic [SCALE_W-1:0] spec_scale = '0;
    logic [SUM_W-1:0]   bin_power [NUM_BINS];

    in_t  pending_beats[$];
    out_t expected_readouts[$];

    logic item_taken = 1'b0;
    int   send_gap = 0;
    int   pop_gap = 0;
    int   send_idle_pct = 0;
    int   pop_stall_pct = 0;
    int   idle_cycles = 0;
    int   fail_count = 0;
    int   acc_beats = 0;
    int   read_beats = 0;
    int   flagged_reads = 0;
    int   clip_events = 0;
    int   setting_count = 0;

    averaged_power_spectrum_accumulator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Floor square root, one result bit per step from the top
    function automatic logic [31:0] floor_sqrt(input logic [63:0] x);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int i = 31; i >= 0; i--)
        begin
            trial = root | (32'd1 << i);
            if (64'(trial) * 64'(trial) <= x)
                root = trial;
        end
        return root;
    endfunction

    // Update bin sums for an accumulate beat, queue the readout for a read beat
    task automatic predict_bin_beat(input in_t beat);
        longint      re_v;
        longint      im_v;
        logic [63:0] gain;
        logic [63:0] total;
        logic [89:0] product;
        out_t        want;
        bit          live;
        live = ({1'b0, beat.bin} < spec_bins);
        if (beat.opcode == OP_ACCUM)
        begin
            acc_beats++;
            if (live)
            begin
                re_v = $signed(beat.sample_re);
                im_v = $signed(beat.sample_im);
                if (re_v < 0)
                    re_v = -re_v;
                if (im_v < 0)
                    im_v = -im_v;
                gain = 64'(re_v * re_v) + 64'(im_v * im_v);
                total = 64'(bin_power[beat.bin]) + gain;
                if (total > SUM_LIMIT)
                begin
                    total = SUM_LIMIT;
                    clip_events++;
                end
                bin_power[beat.bin] = total[SUM_W-1:0];
            end
        end
        else
        begin
            read_beats++;
            want.freq_index = spec_first_freq + FREQ_W'(beat.bin);
            if (live)
            begin
                product = 90'(bin_power[beat.bin]) * 90'(spec_scale);
                want.amplitude = floor_sqrt(64'(product[89:32]));
                want.bin_error = 1'b0;
            end
            else
            begin
                want.amplitude = '0;
                want.bin_error = 1'b1;
                flagged_reads++;
            end
            expected_readouts.push_back(want);
        end
    endtask

    // Driver: hold a beat until taken, insert idle bursts between beats
    always @(negedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else if (push && !item_taken)
            push <= 1'b1;
        else if (send_gap > 0)
        begin
            send_gap <= send_gap - 1;
            push <= 1'b0;
        end
        else if ($urandom_range(0, 99) < send_idle_pct)
        begin
            send_gap <= $urandom_range(0, 9);
            push <= 1'b0;
        end
        else if (pending_beats.size() > 0)
        begin
            push <= 1'b1;
            item <= pending_beats.pop_front();
        end
        else
            push <= 1'b0;
    end

    // Result side: stall pop in bursts
    always @(negedge clk)
    begin
        if (pop_gap > 0)
        begin
            pop_gap <= pop_gap - 1;
            pop <= 1'b0;
        end
        else if ($urandom_range(0, 99) < pop_stall_pct)
        begin
            pop_gap <= $urandom_range(0, 9);
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    // Monitor: check result beats, predict input beats, watch for a hang
    always @(posedge clk)
    begin : monitor_blk
        out_t want;
        bit   moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (pop && !empty)
            begin
                moved = 1'b1;
                if (expected_readouts.size() == 0)
                begin
                    if (fail_count < REPORT_LIMIT)
                        $display("Unexpected result: freq %0d amp %0d err %0b",
                                 result.freq_index, result.amplitude, result.bin_error);
                    fail_count++;
                end
                else
                begin
                    want = expected_readouts.pop_front();
                    if (result.freq_index !== want.freq_index
                        || result.amplitude !== want.amplitude
                        || result.bin_error !== want.bin_error)
                    begin
                        if (fail_count < REPORT_LIMIT)
                            $display("Mismatch: freq %0d/%0d amp %0d/%0d err %0b/%0b (exp/got)",
                                     want.freq_index, result.freq_index,
                                     want.amplitude, result.amplitude,
                                     want.bin_error, result.bin_error);
                        fail_count++;
                    end
                end
            end
            if (push && !full)
            begin
                moved = 1'b1;
                predict_bin_beat(item);
            end
            item_taken <= push && !full;
            if (moved)
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no beat for %0d cycles", idle_cycles);
                $display("Some tests failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_beat(input op_t op, input int bin_n,
                              input logic signed [SAMPLE_W-1:0] re,
                              input logic signed [SAMPLE_W-1:0] im);
        in_t beat;
        beat.opcode = op;
        beat.bin = BIN_W'(bin_n);
        beat.sample_re = re;
        beat.sample_im = im;
        pending_beats.push_back(beat);
    endtask

    // Write one register while idle and mirror it in the predictor
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_BINS_IN_USE: spec_bins = data[BINS_W-1:0];
            REG_FIRST_FREQ:  spec_first_freq = data;
            REG_AMP_SCALE:   spec_scale = data;
            default:         ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic write_setting(input logic [CFG_DATA_W-1:0] bins_data,
                                 input logic [CFG_DATA_W-1:0] first_data,
                                 input logic [CFG_DATA_W-1:0] scale_data);
        write_reg(REG_BINS_IN_USE, bins_data);
        write_reg(REG_FIRST_FREQ, first_data);
        write_reg(REG_AMP_SCALE, scale_data);
        write_reg(REG_UNUSED, $urandom());
        setting_count++;
    endtask

    // Hold off until all beats are sent and all readouts are back, then let the pipe empty
    task automatic settle();
        do
            @(negedge clk);
        while (pending_beats.size() > 0 || push || expected_readouts.size() > 0);
        repeat (LATENCY_PAD) @(negedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       return '0;
            3:       return SAMPLE_W'($urandom_range(0, 7)) - SAMPLE_W'(4);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // Stimulus sequence
    initial
    begin : sequencer
        int   sel;
        int   span;
        int   hot;
        int   bin_n;
        logic [CFG_DATA_W-1:0] bins_data;
        logic [CFG_DATA_W-1:0] first_data;
        logic [CFG_DATA_W-1:0] scale_data;
        for (int i = 0; i < NUM_BINS; i++)
            bin_power[i] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        send_idle_pct = 10;
        pop_stall_pct = 10;

        // Reset settings: zero scale, full bin range
        queue_beat(OP_ACCUM, 2, SAMPLE_MAX, SAMPLE_MAX);
        queue_beat(OP_READ, 2, '0, '0);
        queue_beat(OP_READ, 1023, '0, '0);
        settle();

        // Full scale, frequency index wraps past the top
        write_setting(32'd1024, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        queue_beat(OP_ACCUM, 0, SAMPLE_MIN, '0);
        queue_beat(OP_READ, 0, '0, '0);
        queue_beat(OP_ACCUM, 1023, SAMPLE_MAX, SAMPLE_MIN);
        queue_beat(OP_READ, 1023, '0, '0);
        queue_beat(OP_ACCUM, 1023, SAMPLE_MIN, SAMPLE_MIN);
        queue_beat(OP_READ, 1023, '0, '0);
        queue_beat(OP_ACCUM, 512, -24'sd1, 24'sd1);
        queue_beat(OP_READ, 512, '0, '0);
        queue_beat(OP_READ, 3, '0, '0);
        queue_beat(OP_ACCUM, 0, 24'sh555555, 24'shAAAAAA);
        queue_beat(OP_READ, 0, '0, '0);
        settle();

        // One bin in use, upper data bits must be dropped
        write_setting(32'hFFFF_F801, 32'd0, 32'h8000_0000);
        queue_beat(OP_ACCUM, 1, SAMPLE_MAX, SAMPLE_MAX);
        queue_beat(OP_READ, 1, '0, '0);
        queue_beat(OP_READ, 0, '0, '0);
        queue_beat(OP_ACCUM, 0, SAMPLE_MAX, '0);
        queue_beat(OP_READ, 0, '0, '0);
        queue_beat(OP_READ, 1023, '0, '0);
        settle();

        // No bins in use: everything is out of range
        write_setting(32'h0000_0800, 32'h1234_5678, 32'hFFFF_FFFF);
        queue_beat(OP_ACCUM, 0, SAMPLE_MIN, SAMPLE_MIN);
        queue_beat(OP_READ, 0, '0, '0);
        queue_beat(OP_READ, 1023, '0, '0);
        settle();

        // Drive one bin to a large sum with full-scale samples
        write_setting(32'd1024, $urandom(), 32'hFFFF_FFFF);
        for (int n = 0; n < SAT_BEATS; n++)
        begin
            if (n % 128 == 127)
                queue_beat(OP_READ, HOT_BIN, '0, '0);
            else
                queue_beat(OP_ACCUM, HOT_BIN, SAMPLE_MIN, SAMPLE_MIN);
        end
        queue_beat(OP_READ, HOT_BIN, '0, '0);
        settle();

        // Random phases across settings, the last one without idling
        for (int k = 0; k < RANDOM_PHASES; k++)
        begin
            sel = (k < 6) ? k : $urandom_range(0, 5);
            case (sel)
                0:       bins_data = 32'd1;
                1:       bins_data = 32'd1024;
                2:       bins_data = 32'd0;
                3:       bins_data = 32'hFFFF_FFFF;
                4:       bins_data = $urandom_range(1, 1024);
                default: bins_data = $urandom_range(2, 64);
            endcase
            bins_data[31:BINS_W] = (32 - BINS_W)'($urandom());
            case (k % 3)
                0:       first_data = 32'd0;
                1:       first_data = 32'hFFFF_FFFF;
                default: first_data = $urandom();
            endcase
            case ((k < 4) ? k : $urandom_range(1, 4))
                0:       scale_data = 32'hFFFF_FFFF;
                2:       scale_data = 32'd0;
                3:       scale_data = 32'd1;
                default: scale_data = $urandom();
            endcase
            write_setting(bins_data, first_data, scale_data);
            if (k == RANDOM_PHASES - 1)
            begin
                send_idle_pct = 0;
                pop_stall_pct = 0;
            end
            else
            begin
                send_idle_pct = (k % 3 == 0) ? 0 : ((k % 3 == 1) ? 6 : 30);
                pop_stall_pct = (k % 3 == 2) ? 0 : ((k % 3 == 1) ? 30 : 6);
            end
            // Four in ten beats land on a few hot bins so sums grow
            span = (spec_bins == 0) ? NUM_BINS : ((spec_bins > NUM_BINS) ? NUM_BINS : spec_bins);
            hot = (span > 16) ? 16 : span;
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: bin_n = $urandom_range(0, hot - 1);
                    4, 5, 6:    bin_n = $urandom_range(0, span - 1);
                    default:    bin_n = $urandom_range(0, NUM_BINS - 1);
                endcase
                if ($urandom_range(0, 99) < 35)
                    queue_beat(OP_READ, bin_n, pick_sample(), pick_sample());
                else
                    queue_beat(OP_ACCUM, bin_n, pick_sample(), pick_sample());
            end
            settle();
        end

        $display("Covered %0d accumulate and %0d read beats over %0d register settings;",
                 acc_beats, read_beats, setting_count);
        $display("%0d reads flagged out of range, %0d accumulates clipped at the sum limit.",
                 flagged_reads, clip_events);
        if (fail_count == 0 && expected_readouts.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
src/apsa_pkg.sv
src/apsa_front.sv
src/apsa_fifo.sv
src/apsa_back.sv
src/apsa_isqrt.sv
src/averaged_power_spectrum_accumulator.sv
test/tb.sv
